// ----- src/binary_grid_neighbor_count_threshold_macros.svh -----
// Assertion macros shared by the grid neighbour count filter.
`ifndef BINARY_GRID_NEIGHBOR_COUNT_THRESHOLD_MACROS_SVH
`define BINARY_GRID_NEIGHBOR_COUNT_THRESHOLD_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BGNCT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BGNCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/bgnct_pkg.sv -----
// Shared types and constants of the grid neighbour count filter.
package bgnct_pkg;

	localparam int DEF_MAX_WIDTH = 256;

	localparam int RW_W  = 9;
	localparam int TH_W  = 4;
	localparam int TOT_W = 17;
	localparam logic [TOT_W-1:0] TOTAL_MAX = 17'h1FFFF;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam logic [0:0] REG_ROW_WIDTH = 1'b0;
	localparam logic [0:0] REG_THRESHOLD = 1'b1;

	localparam logic [RW_W-1:0] ROW_WIDTH_RST = 9'd256;
	localparam logic [TH_W-1:0] THRESHOLD_RST = 4'd4;

	typedef struct packed {
		logic [RW_W-1:0] row_width;
		logic [TH_W-1:0] threshold;
	} cfg_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		logic            write;
		logic            row_end;
		logic            frame_end;
		logic            occ;
		logic [TH_W-1:0] threshold;
	} cell_ctrl_t;

endpackage

// ----- src/bgnct_regs.sv -----
// Configuration registers behind the APB-style port.
module bgnct_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bgnct_pkg::CFG_AW-1:0]   paddr,
	input  logic [bgnct_pkg::CFG_DW-1:0]   pwdata,
	output logic [bgnct_pkg::CFG_DW-1:0]   prdata,
	output logic                           pready,
	output bgnct_pkg::cfg_t                cfg
);

	logic [0:0]      reg_idx;
	logic            wr_en;
	bgnct_pkg::cfg_t cfg_q;

	assign reg_idx = paddr[bgnct_pkg::CFG_AW-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_width <= bgnct_pkg::ROW_WIDTH_RST;
			cfg_q.threshold <= bgnct_pkg::THRESHOLD_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				bgnct_pkg::REG_ROW_WIDTH: begin
					cfg_q.row_width <= pwdata[bgnct_pkg::RW_W-1:0];
				end
				bgnct_pkg::REG_THRESHOLD: begin
					cfg_q.threshold <= pwdata[bgnct_pkg::TH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			bgnct_pkg::REG_ROW_WIDTH: prdata = bgnct_pkg::CFG_DW'(cfg_q.row_width);
			bgnct_pkg::REG_THRESHOLD: prdata = bgnct_pkg::CFG_DW'(cfg_q.threshold);
			default:                  prdata = '0;
		endcase
	end

endmodule

// ----- src/bgnct_cell.sv -----
// One column of the line store: three row bits, window judgement, hit sum link.
module bgnct_cell #(
	parameter int MAX_WIDTH = bgnct_pkg::DEF_MAX_WIDTH,
	parameter int INDEX     = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bgnct_pkg::cell_ctrl_t        ctrl,
	input  logic [$clog2(MAX_WIDTH)-1:0] col,
	input  logic                         up_l,
	input  logic                         up_r,
	input  logic                         mid_l,
	input  logic                         mid_r,
	input  logic                         low_l,
	input  logic                         low_r,
	input  logic [$clog2(MAX_WIDTH)+1:0] pend_in,
	output logic                         up,
	output logic                         mid,
	output logic                         low,
	output logic [$clog2(MAX_WIDTH)+1:0] pend_out
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int PEND_W = COL_W + 2;

	logic              up_q;
	logic              mid_q;
	logic              low_q;
	logic              low_cur;
	logic [3:0]        cnt_m;
	logic [3:0]        cnt_l;
	logic              hit_m;
	logic              hit_l;
	logic [PEND_W-1:0] pend_q;

	// The incoming cell is visible to the window in the cycle it arrives.
	assign low_cur = (ctrl.write && col == COL_W'(INDEX)) ? ctrl.occ : low_q;

	assign cnt_m = 4'(up_l) + 4'(up_q) + 4'(up_r) + 4'(mid_l) + 4'(mid_r)
	             + 4'(low_l) + 4'(low_cur) + 4'(low_r);
	// Last row of the frame: nothing below it.
	assign cnt_l = 4'(mid_l) + 4'(mid_q) + 4'(mid_r) + 4'(low_l) + 4'(low_r);

	assign hit_m = (ctrl.row_end || ctrl.frame_end) && mid_q && (cnt_m < ctrl.threshold);
	assign hit_l = ctrl.frame_end && low_cur && (cnt_l < ctrl.threshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q   <= 1'b0;
			mid_q  <= 1'b0;
			low_q  <= 1'b0;
			pend_q <= '0;
		end else begin
			// Hand the partial hit sum one column towards the sink.
			pend_q <= pend_in + PEND_W'(hit_m) + PEND_W'(hit_l);
			if (ctrl.frame_end) begin
				up_q  <= 1'b0;
				mid_q <= 1'b0;
				low_q <= 1'b0;
			end else if (ctrl.row_end) begin
				up_q  <= mid_q;
				mid_q <= low_cur;
				low_q <= 1'b0;
			end else begin
				low_q <= low_cur;
			end
		end
	end

	assign up       = up_q;
	assign mid      = mid_q;
	assign low      = low_cur;
	assign pend_out = pend_q;

endmodule

// ----- src/binary_grid_neighbor_count_threshold.sv -----
// Top level of the 3x3 neighbour count filter over a streamed binary grid.
// Throughput: one cell per cycle within a frame, every row held in a chain of column cells.
// Per-column hits ripple down the cell chain to the total, one column a cycle.
// After the frame_end transfer the hit chain drains, then the frame total is registered.
// The input stalls until then, longer while the previous total waits.
// Reset clears the line bits, column counter and total; row_width 256, threshold 4.
`include "binary_grid_neighbor_count_threshold_macros.svh"

module binary_grid_neighbor_count_threshold #(
	parameter int MAX_WIDTH = bgnct_pkg::DEF_MAX_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bgnct_pkg::CFG_AW-1:0]  paddr,
	input  logic [bgnct_pkg::CFG_DW-1:0]  pwdata,
	output logic [bgnct_pkg::CFG_DW-1:0]  prdata,
	output logic                          pready,
	input  logic                          cell_valid,
	output logic                          cell_stall,
	input  logic                          occupied,
	input  logic                          frame_end,
	output logic                          total_valid,
	input  logic                          total_stall,
	output logic [bgnct_pkg::TOT_W-1:0]   sparse_cell_total
);

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int PEND_W  = COL_W + 2;
	localparam int LEN_W   = COL_W + 1;
	localparam int WCMP_W  = (LEN_W > bgnct_pkg::RW_W) ? LEN_W : bgnct_pkg::RW_W;
	localparam int DRAIN_W = $clog2(MAX_WIDTH + 1);
	localparam int TOT_W   = bgnct_pkg::TOT_W;

	bgnct_pkg::cfg_t       cfg;
	bgnct_pkg::cell_ctrl_t ctrl;

	logic [COL_W-1:0]   col_q;
	logic               busy_q;
	logic [DRAIN_W-1:0] drain_q;
	logic [TOT_W-1:0]   total_q;
	logic               total_valid_q;
	logic [TOT_W-1:0]   total_data_q;

	logic [WCMP_W-1:0] rw_ext;
	logic [WCMP_W-1:0] w_eff;
	logic [WCMP_W-1:0] len_ext;
	logic              row_done;
	logic              accept;
	logic              load;
	logic [TOT_W:0]    tot_sum;

	logic              up_v   [MAX_WIDTH];
	logic              mid_v  [MAX_WIDTH];
	logic              low_v  [MAX_WIDTH];
	logic [PEND_W-1:0] pend_v [MAX_WIDTH];

	bgnct_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Zero width acts as one, oversize width as the line length.
	assign rw_ext   = WCMP_W'(cfg.row_width);
	assign w_eff    = (rw_ext == '0) ? WCMP_W'(1) :
	                  (rw_ext > WCMP_W'(MAX_WIDTH)) ? WCMP_W'(MAX_WIDTH) : rw_ext;
	assign len_ext  = WCMP_W'(col_q) + WCMP_W'(1);
	assign row_done = (len_ext >= w_eff);

	assign accept     = cell_valid && !busy_q;
	assign cell_stall = busy_q;

	assign ctrl.write     = accept;
	assign ctrl.row_end   = accept && !frame_end && row_done;
	assign ctrl.frame_end = accept && frame_end;
	assign ctrl.occ       = occupied;
	assign ctrl.threshold = cfg.threshold;

	for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
		logic              up_l, up_r, mid_l, mid_r, low_l, low_r;
		logic [PEND_W-1:0] pend_in;

		if (k == 0) begin : g_left_edge
			assign up_l  = 1'b0;
			assign mid_l = 1'b0;
			assign low_l = 1'b0;
		end else begin : g_left
			assign up_l  = up_v[k-1];
			assign mid_l = mid_v[k-1];
			assign low_l = low_v[k-1];
		end

		if (k == MAX_WIDTH - 1) begin : g_right_edge
			assign up_r    = 1'b0;
			assign mid_r   = 1'b0;
			assign low_r   = 1'b0;
			assign pend_in = '0;
		end else begin : g_right
			assign up_r    = up_v[k+1];
			assign mid_r   = mid_v[k+1];
			assign low_r   = low_v[k+1];
			assign pend_in = pend_v[k+1];
		end

		bgnct_cell #(
			.MAX_WIDTH (MAX_WIDTH),
			.INDEX     (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.col      (col_q),
			.up_l     (up_l),
			.up_r     (up_r),
			.mid_l    (mid_l),
			.mid_r    (mid_r),
			.low_l    (low_l),
			.low_r    (low_r),
			.pend_in  (pend_in),
			.up       (up_v[k]),
			.mid      (mid_v[k]),
			.low      (low_v[k]),
			.pend_out (pend_v[k])
		);
	end

	assign tot_sum = {1'b0, total_q} + (TOT_W + 1)'(pend_v[0]);

	// Chain drained and output register free: move the frame total out.
	assign load = busy_q && (drain_q == '0) && (!total_valid_q || !total_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			busy_q        <= 1'b0;
			drain_q       <= '0;
			total_q       <= '0;
			total_valid_q <= 1'b0;
		end else begin
			if (ctrl.frame_end || ctrl.row_end) begin
				col_q <= '0;
			end else if (accept) begin
				col_q <= col_q + COL_W'(1);
			end

			if (ctrl.frame_end) begin
				busy_q  <= 1'b1;
				drain_q <= DRAIN_W'(MAX_WIDTH);
			end else begin
				if (drain_q != '0) begin
					drain_q <= drain_q - DRAIN_W'(1);
				end
				if (load) begin
					busy_q <= 1'b0;
				end
			end

			if (load) begin
				total_q <= '0;
			end else if (tot_sum > (TOT_W + 1)'(bgnct_pkg::TOTAL_MAX)) begin
				total_q <= bgnct_pkg::TOTAL_MAX;
			end else begin
				total_q <= tot_sum[TOT_W-1:0];
			end

			if (load) begin
				total_valid_q <= 1'b1;
			end else if (total_valid_q && !total_stall) begin
				total_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			total_data_q <= total_q;
		end
	end

	assign total_valid       = total_valid_q;
	assign sparse_cell_total = total_data_q;

	`BGNCT_ASSERT_NEXT(a_frame_end_stalls, ctrl.frame_end, cell_stall && drain_q != '0, "input not held after frame end")
	`BGNCT_ASSERT_SAME(a_drain_only_busy, drain_q != '0, busy_q, "hit chain draining outside a frame end")
	`BGNCT_ASSERT_SAME(a_load_chain_empty, load, pend_v[0] == '0, "frame total taken with hits still in flight")
	`BGNCT_ASSERT_NEXT(a_row_end_column, ctrl.row_end, col_q == '0, "column not restarted after row end")

endmodule
